/* rtl/core/mrr_pkg.sv */
package mrr_pkg;

  localparam int SEED_W = 31;
  localparam int MUL_W  = 15;
  localparam int PROD_W = SEED_W + MUL_W;
  localparam int CNT_W  = 5;

  localparam logic [SEED_W-1:0] MINSTD_MOD = 31'd2147483647;
  localparam logic [MUL_W-1:0]  MINSTD_MUL = 15'd16807;
  localparam logic [SEED_W-1:0] RANGE_RST  = 31'd2147483647;
  localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(SEED_W - 1);

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic              done;
    logic [SEED_W-1:0] seed;
  } lcg_stat_t;

  typedef struct packed {
    logic              done;
    logic [SEED_W-1:0] rem;
  } div_stat_t;

endpackage

/* rtl/core/minstd_random_ranged.sv */
// Draw path: the LCG multiply and mod 2^31-1 reduce registers, then a bit-serial restoring
// divide by range_max; the number is the remainder plus 1. A zero range_max skips both and answers 1.
// A new item is accepted only in the idle state, not while a draw is under way or held by out_ready.
// A load updates the seed and leaves in_ready high.
// Reset (rst_n low, synchronous): seed = 1, range_max = 2147483647, no item pending.
module minstd_random_ranged
  import mrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [SEED_W-1:0] in_seed_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SEED_W-1:0] out_number,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SEED_W-1:0] cfg_range_max
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [SEED_W-1:0] seed_r;
  logic [SEED_W-1:0] range_r;
  logic [SEED_W-1:0] res_r;
  logic [SEED_W-1:0] res_nxt;
  logic              out_valid_r;
  logic [SEED_W-1:0] out_number_r;
  logic              in_acc;
  logic              lcg_start;
  logic              div_start;
  logic              emit;
  lcg_stat_t         lcg_stat;
  div_stat_t         div_stat;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign emit      = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign lcg_start = in_acc && (in_cmd == CMD_DRAW) && (range_r != '0);
  assign div_start = (state_r == ST_MUL) && lcg_stat.done;

  mrr_lcg u_lcg (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (lcg_start),
    .seed_in (seed_r),
    .stat    (lcg_stat)
  );

  mrr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lcg_stat.seed),
    .divisor  (range_r),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_DRAW)) begin
          if (range_r == '0) begin
            res_nxt   = SEED_W'(1);
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (lcg_stat.done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_nxt   = div_stat.rem + SEED_W'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= SEED_W'(1);
      range_r     <= RANGE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        range_r <= cfg_range_max;
      end
      if (in_acc && (in_cmd == CMD_LOAD)) begin
        seed_r <= in_seed_value;
      end else if (div_start) begin
        seed_r <= lcg_stat.seed;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (emit) begin
      out_number_r <= res_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_number = out_number_r;

endmodule

/* rtl/core/mrr_lcg.sv */
module mrr_lcg
  import mrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SEED_W-1:0] seed_in,
  output lcg_stat_t         stat
);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic              mul_vld_r;
  logic              red_vld_r;
  logic [SEED_W-1:0] seed_r;
  logic [SEED_W-1:0] seed_nxt;
  logic [SEED_W-1:0] seed_c;
  logic [SEED_W:0]   fold;

  // seed below 1 is taken as 1
  assign seed_c   = (seed_in == '0) ? SEED_W'(1) : seed_in;
  assign prod_nxt = PROD_W'(seed_c) * PROD_W'(MINSTD_MUL);

  // 2^31 == 1 mod (2^31-1): fold high part onto low part
  assign fold     = {1'b0, prod_r[SEED_W-1:0]} + (SEED_W+1)'(prod_r[PROD_W-1:SEED_W]);
  assign seed_nxt = (fold >= {1'b0, MINSTD_MOD}) ? SEED_W'(fold - {1'b0, MINSTD_MOD})
                                                  : fold[SEED_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      red_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= start;
      red_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_nxt;
    end
    if (mul_vld_r) begin
      seed_r <= seed_nxt;
    end
  end

  assign stat.done = red_vld_r;
  assign stat.seed = seed_r;

endmodule

/* rtl/core/mrr_div.sv */
module mrr_div
  import mrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SEED_W-1:0] dividend,
  input  logic [SEED_W-1:0] divisor,
  output div_stat_t         stat
);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SEED_W-1:0] quo_r;
  logic [SEED_W-1:0] rem_r;
  logic [SEED_W-1:0] dsr_r;
  logic [SEED_W:0]   trial;
  logic [SEED_W-1:0] rem_nxt;

  // restoring step: one dividend bit per cycle
  assign trial   = {rem_r, quo_r[SEED_W-1]};
  assign rem_nxt = (trial >= {1'b0, dsr_r}) ? SEED_W'(trial - {1'b0, dsr_r})
                                            : trial[SEED_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SEED_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign stat.done = done_r;
  assign stat.rem  = rem_r;

endmodule

/* rtl/core/mrr_checker.sv */
module mrr_checker
  import mrr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SEED_W-1:0] out_number
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_number))
    else $error("result item changed while stalled");

  a_out_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_number != '0)
    else $error("drawn number is zero");

  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_DRAW) |=> !in_ready)
    else $error("ready after draw item accepted");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_LOAD) |=> in_ready)
    else $error("load item stalled the input");

endmodule

bind minstd_random_ranged mrr_checker u_mrr_checker (.*);

/* dv/tb_minstd_random_ranged.sv */
module tb_minstd_random_ranged;
  import mrr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [63:0] LCG_MOD = 64'd2147483647;
  localparam bit [63:0] LCG_MUL = 64'd16807;
  localparam logic [SEED_W-1:0] ALL_ONES = '1;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic              cmd;
    logic [SEED_W-1:0] seed_value;
  } lcg_req_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_cmd = CMD_DRAW;
  logic [SEED_W-1:0] in_seed_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SEED_W-1:0] out_number;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SEED_W-1:0] cfg_range_max = '0;

  lcg_req_t          req_queue[$];
  logic [SEED_W-1:0] expected_numbers[$];
  logic [SEED_W-1:0] lcg_seed = 31'd1;
  logic [SEED_W-1:0] lcg_range = ALL_ONES;
  lcg_req_t          cur_req;

  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int in_wait = 0;
  int out_wait = 0;
  int out_hold = 0;
  int in_gap_max = 3;
  int out_gap_max = 3;
  int mismatch_count = 0;

  minstd_random_ranged u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_seed_value (in_seed_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_number    (out_number),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_range_max (cfg_range_max)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // One accepted item: a load sets the seed, a draw queues its number.
  task automatic apply_request(input logic cmd, input logic [SEED_W-1:0] sv);
    bit [63:0]         prod;
    logic [SEED_W-1:0] s;
    if (cmd == CMD_LOAD) begin
      lcg_seed = sv;
      return;
    end
    if (lcg_range == '0) begin
      expected_numbers.push_back(SEED_W'(1));
      return;
    end
    s = (lcg_seed == '0) ? SEED_W'(1) : lcg_seed;
    prod = 64'(s) * LCG_MUL;
    s = SEED_W'(prod % LCG_MOD);
    lcg_seed = s;
    expected_numbers.push_back(SEED_W'(64'd1 + 64'(s) % 64'(lcg_range)));
  endtask

  // Monitor: accepts are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_request(in_cmd, in_seed_value);
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (expected_numbers.size() == 0) begin
          note_mismatch($sformatf("number %0d with no draw pending", out_number));
        end else if (out_number !== expected_numbers[0]) begin
          note_mismatch($sformatf("number got %0d want %0d", out_number,
                                  expected_numbers[0]));
          void'(expected_numbers.pop_front());
        end else begin
          void'(expected_numbers.pop_front());
        end
      end
    end
  end

  // Driver: one item at a time from req_queue, random gap after each accept.
  always @(negedge clk) begin
    if (in_taken || !in_valid) begin
      if (in_taken) in_wait = $urandom_range(0, in_gap_max);
      in_taken = 1'b0;
      if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (req_queue.size() > 0) begin
        cur_req = req_queue.pop_front();
        in_valid      <= 1'b1;
        in_cmd        <= cur_req.cmd;
        in_seed_value <= cur_req.seed_value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall after each item, plus an optional long hold-off.
  always @(negedge clk) begin
    if (out_taken) out_wait = $urandom_range(0, out_gap_max);
    out_taken = 1'b0;
    if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_item(input logic cmd, input logic [SEED_W-1:0] sv);
    lcg_req_t r;
    r.cmd = cmd;
    r.seed_value = sv;
    req_queue.push_back(r);
  endtask

  task automatic push_random(input int n, input int load_pct);
    logic              cmd;
    logic [SEED_W-1:0] sv;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(0, 99) < load_pct) ? CMD_LOAD : CMD_DRAW;
      case ($urandom_range(0, 7))
        0: sv = '0;
        1: sv = ALL_ONES;
        2: sv = ALL_ONES - SEED_W'(1);
        3: sv = SEED_W'(1);
        default: sv = SEED_W'($urandom());
      endcase
      push_item(cmd, sv);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (req_queue.size() != 0 || in_valid || expected_numbers.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_range(input logic [SEED_W-1:0] v);
    @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_range_max <= v;
    do @(posedge clk);
    while (!cfg_ready);
    lcg_range = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input logic [SEED_W-1:0] rmax, input int n, input int load_pct,
                            input int in_max, input int out_max, input int hold);
    write_range(rmax);
    in_gap_max  = in_max;
    out_gap_max = out_max;
    push_random(n, load_pct);
    out_hold = hold;
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset seed and reset range
    push_item(CMD_DRAW, ALL_ONES);
    push_item(CMD_DRAW, '0);
    push_item(CMD_LOAD, '0);
    push_item(CMD_DRAW, '0);
    push_item(CMD_DRAW, '0);
    push_item(CMD_LOAD, ALL_ONES);
    push_item(CMD_DRAW, '0);
    push_item(CMD_DRAW, '0);
    push_item(CMD_LOAD, 31'h5555_5555);
    push_item(CMD_LOAD, 31'h2AAA_AAAA);
    push_item(CMD_DRAW, '0);
    push_item(CMD_LOAD, SEED_W'(1));
    push_item(CMD_DRAW, ALL_ONES);
    wait_idle();

    // zero range: draws return 1, seed frozen, loads still land
    write_range('0);
    push_item(CMD_DRAW, '0);
    push_item(CMD_LOAD, SEED_W'(12345));
    push_item(CMD_DRAW, '0);
    push_item(CMD_LOAD, '0);
    push_item(CMD_DRAW, ALL_ONES);
    wait_idle();

    write_range(SEED_W'(1));
    push_item(CMD_DRAW, '0);
    push_item(CMD_DRAW, '0);
    push_item(CMD_LOAD, ALL_ONES);
    push_item(CMD_DRAW, '0);
    wait_idle();

    run_random(ALL_ONES, 100, 10, 9, 9, 0);
    run_random(SEED_W'($urandom()), 100, 10, 0, 0, 0);
    run_random(SEED_W'(1), 60, 15, 9, 3, 0);
    run_random('0, 40, 20, 5, 5, 0);
    run_random(SEED_W'($urandom_range(2, 16)), 100, 5, 0, 0, 400);
    run_random(SEED_W'($urandom()), 100, 10, 9, 9, 0);
    run_random(SEED_W'(2), 60, 10, 2, 9, 0);
    run_random(SEED_W'(1) << 30, 80, 10, 9, 0, 0);
    run_random(SEED_W'($urandom_range(1, 1000)), 100, 10, 0, 9, 0);
    run_random(ALL_ONES, 60, 25, 4, 4, 0);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
